// ===== src/ecsm_pkg.sv =====
// Shared types and constants for the elliptic-curve scalar multiplier.
package ecsm_pkg;

  localparam int unsigned RegW = 64;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFieldPrime = 2'd0,
    CfgCurveA     = 2'd1,
    CfgGroupOrder = 2'd2
  } cfg_idx_e;

  localparam logic [RegW-1:0] FieldPrimeRst = 64'hFFFF_FFFF_FFFF_FFC5;
  localparam logic [RegW-1:0] CurveARst     = 64'h0;
  localparam logic [RegW-1:0] GroupOrderRst = 64'hFFFF_FFFF_FFFF_FFFF;

endpackage

// ===== src/ec_scalar_multiply.sv =====
// Elliptic-curve scalar multiplier: affine double-and-add on one shared serial unit.
// Sequence: a and the base coordinates are reduced mod p and the scalar mod the group order,
// then per scalar bit, LSB first, a doubling and, for a set bit, an addition, each with an
// inversion by Euclid steps; up to about 93 steps at 64 bits.
// One word at a time: in_stall_o is high outside idle, and the result waits in an output
// register. Reset: asynchronous, active low; config, control and result registers reset.
module ec_scalar_multiply #(
  parameter int unsigned FIELD_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ecsm_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ecsm_pkg::RegW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [63:0]                  point_x_i,
  input  logic [63:0]                  point_y_i,
  input  logic                         point_is_infinity_i,
  input  logic signed [63:0]           scalar_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [63:0]                  result_x_o,
  output logic [63:0]                  result_y_o,
  output logic                         result_is_infinity_o
);
  import ecsm_pkg::*;

  localparam int unsigned W = FIELD_BITS;
  localparam int unsigned CW = $clog2(64 + 1);

  // sequencer states
  localparam logic [4:0] S_IDLE = 5'd0, S_CHK = 5'd1, S_RED = 5'd2, S_KRED = 5'd3,
    S_LOOP = 5'd4, S_PADD = 5'd5, S_D0 = 5'd6, S_D1 = 5'd7, S_D2 = 5'd8, S_INV = 5'd9,
    S_INVQ = 5'd10, S_INVM = 5'd11, S_SL = 5'd12, S_X0 = 5'd13, S_X1 = 5'd14,
    S_Y0 = 5'd15, S_Y1 = 5'd16, S_WR = 5'd17, S_FIN = 5'd18;

  // unit ops
  localparam logic OP_MUL = 1'b0, OP_DIV = 1'b1;

  logic [RegW-1:0] prime_q, curve_a_q, order_q;

  logic [4:0] st_q, st_d;
  logic [W-1:0] p_q, a_q, bx_q, by_q, ax_q, ay_q, m_q, t_q, rx_q, ry_q, q_q;
  logic binf_q, ainf_q, rinf_q, dst_acc_q, neg_q;
  logic [63:0] k_q;
  logic [1:0] red_q;
  // Euclid registers
  logic [W-1:0] r0_q, r1_q, c0_q, c1_q;
  logic [W-1:0] res_x_q, res_y_q;
  logic res_inf_q, ov_q;

  // shared serial unit: multiply-mod (shift-add) or divide (restoring), 64-bit operands
  logic op_q;
  logic busy_q;
  logic [CW-1:0] cnt_q;
  logic [63:0] ua_q, ub_q, um_q, uacc_q, uquo_q;
  logic ustart;
  logic uop;
  logic [63:0] uin_a, uin_b, uin_m;
  logic [64:0] dbl_acc, s1, s2;
  logic [63:0] acc2, acc3, umul;
  logic [64:0] rem_sh;
  logic [63:0] uquot, udivrem;
  logic udone;
  logic [W-1:0] ures;

  logic in_acc, out_acc, scal_neg;
  logic [63:0] kmag;

  // operands of the current addition: P = acc (or base when doubling), Q = base
  logic [W-1:0] px, py, ysub;
  logic pinf, x_same, pq_same, add_triv;

  function automatic logic [W-1:0] fsub(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] p);
    logic [W-1:0] d;
    d = x - y;
    if (x < y) d = d + p;
    return d;
  endfunction

  function automatic logic [W-1:0] fadd(input logic [W-1:0] x, input logic [W-1:0] y,
                                        input logic [W-1:0] p);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[W-1:0];
  endfunction

  // operand widening to the unit
  function automatic logic [63:0] wx(input logic [W-1:0] v);
    return 64'(v);
  endfunction

  always_comb begin
    // multiply step: acc = 2acc mod m; if bit then acc += a mod m
    dbl_acc = {uacc_q, 1'b0};
    acc2 = (dbl_acc >= {1'b0, um_q}) ? 64'(dbl_acc - {1'b0, um_q}) : dbl_acc[63:0];
    s1 = {1'b0, acc2} + {1'b0, ua_q};
    acc3 = (s1 >= {1'b0, um_q}) ? 64'(s1 - {1'b0, um_q}) : s1[63:0];
    // divide step: remainder in uacc, dividend bits shifted out of ua
    rem_sh = {uacc_q, ua_q[63]};
    s2 = rem_sh - {1'b0, ub_q};
  end
  assign umul = ub_q[63] ? acc3 : acc2;
  assign uquot = s2[64] ? {uquo_q[62:0], 1'b0} : {uquo_q[62:0], 1'b1};
  assign udivrem = s2[64] ? rem_sh[63:0] : s2[63:0];
  assign ures = umul[W-1:0];
  assign udone = busy_q && (cnt_q == CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
    end else if (ustart) begin
      busy_q <= 1'b1;
      cnt_q <= CW'(64);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ustart) begin
      op_q <= uop;
      ua_q <= uin_a;
      ub_q <= uin_b;
      um_q <= uin_m;
      uacc_q <= '0;
      uquo_q <= '0;
    end else if (busy_q) begin
      if (op_q == OP_MUL) begin
        uacc_q <= umul;
        ub_q <= {ub_q[62:0], 1'b0};
      end else begin
        uacc_q <= udivrem;
        uquo_q <= uquot;
        ua_q <= {ua_q[62:0], 1'b0};
      end
    end
  end

  assign in_acc = in_valid_i && !in_stall_o;
  assign out_acc = ov_q && !out_stall_i;
  assign in_stall_o = (st_q != S_IDLE);
  assign scal_neg = scalar_i[63];
  assign kmag = scal_neg ? (~$unsigned(scalar_i) + 64'd1) : $unsigned(scalar_i);

  assign px = dst_acc_q ? ax_q : bx_q;
  assign py = dst_acc_q ? ay_q : by_q;
  assign pinf = dst_acc_q ? ainf_q : binf_q;
  assign x_same = (px == bx_q);
  assign pq_same = x_same && (py == by_q);
  assign add_triv = binf_q || pinf || (x_same && !(pq_same && py != '0));
  assign ysub = fsub(rx_q, px, p_q);

  // unit launch on the first idle cycle of each arithmetic state
  always_comb begin
    ustart = 1'b0;
    uop = OP_MUL;
    uin_a = '0;
    uin_b = '0;
    uin_m = wx(p_q);
    if (!busy_q) begin
      case (st_q)
        S_RED: begin
          ustart = 1'b1; uop = OP_DIV; uin_b = wx(p_q);
          case (red_q)
            2'd0: uin_a = wx(a_q);
            2'd1: uin_a = wx(bx_q);
            default: uin_a = wx(by_q);
          endcase
        end
        S_KRED: if (order_q != '0) begin
          ustart = 1'b1; uop = OP_DIV; uin_a = k_q; uin_b = order_q;
        end
        S_D0: begin ustart = 1'b1; uin_a = wx(px); uin_b = wx(px); end
        S_D1: begin ustart = 1'b1; uin_a = wx(t_q); uin_b = 64'd3; end
        S_D2: begin ustart = 1'b1; uin_a = wx(py); uin_b = 64'd2; end
        S_INVQ: begin ustart = 1'b1; uop = OP_DIV; uin_a = wx(r0_q); uin_b = wx(r1_q); end
        S_INVM: begin ustart = 1'b1; uin_a = wx(c1_q); uin_b = wx(q_q); end
        S_SL: begin ustart = 1'b1; uin_a = wx(t_q); uin_b = wx(c0_q); end
        S_X0: begin ustart = 1'b1; uin_a = wx(m_q); uin_b = wx(m_q); end
        S_Y0: begin ustart = 1'b1; uin_a = wx(m_q); uin_b = wx(ysub); end
        default: ;
      endcase
    end
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (in_acc) st_d = S_CHK;
      S_CHK: st_d = (p_q < W'(2) || binf_q) ? S_FIN : S_RED;
      S_RED: if (udone && red_q == 2'd2) st_d = S_KRED;
      S_KRED: if (order_q == '0 || udone) st_d = S_LOOP;
      S_LOOP: st_d = (k_q == '0) ? S_FIN : S_PADD;
      S_PADD: st_d = add_triv ? S_WR : (pq_same ? S_D0 : S_INV);
      S_D0: if (udone) st_d = S_D1;
      S_D1: if (udone) st_d = S_D2;
      S_D2: if (udone) st_d = S_INV;
      S_INV: st_d = (r1_q == '0) ? S_SL : S_INVQ;
      S_INVQ: if (udone) st_d = S_INVM;
      S_INVM: if (udone) st_d = S_INV;
      S_SL: if (udone) st_d = S_X0;
      S_X0: if (udone) st_d = S_X1;
      S_X1: st_d = S_Y0;
      S_Y0: if (udone) st_d = S_Y1;
      S_Y1: st_d = S_WR;
      S_WR: st_d = dst_acc_q ? S_PADD : S_LOOP;
      S_FIN: if (!ov_q || out_acc) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_q <= FieldPrimeRst;
      curve_a_q <= CurveARst;
      order_q <= GroupOrderRst;
      st_q <= S_IDLE;
      ov_q <= 1'b0;
      res_x_q <= '0;
      res_y_q <= '0;
      res_inf_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgFieldPrime: prime_q <= cfg_data_i;
          CfgCurveA:     curve_a_q <= cfg_data_i;
          CfgGroupOrder: order_q <= cfg_data_i;
          default: ;
        endcase
      end
      st_q <= st_d;
      if (st_q == S_FIN && (!ov_q || out_acc)) begin
        ov_q <= 1'b1;
        res_inf_q <= ainf_q;
        res_x_q <= ainf_q ? '0 : ax_q;
        res_y_q <= ainf_q ? '0 : ay_q;
      end else if (out_acc) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: if (in_acc) begin
        p_q <= prime_q[W-1:0];
        a_q <= curve_a_q[W-1:0];
        bx_q <= point_x_i[W-1:0];
        by_q <= point_y_i[W-1:0];
        binf_q <= point_is_infinity_i;
        ainf_q <= 1'b1;
        k_q <= kmag;
        neg_q <= scal_neg;
        red_q <= '0;
      end
      S_RED: if (udone) begin
        case (red_q)
          2'd0: a_q <= udivrem[W-1:0];
          2'd1: bx_q <= udivrem[W-1:0];
          default: by_q <= neg_q ? fsub('0, udivrem[W-1:0], p_q) : udivrem[W-1:0];
        endcase
        red_q <= red_q + 2'd1;
      end
      S_KRED: if (udone) k_q <= udivrem;
      S_LOOP: dst_acc_q <= k_q[0];
      S_PADD: begin
        if (binf_q) begin
          rx_q <= px; ry_q <= py; rinf_q <= pinf;
        end else if (pinf) begin
          rx_q <= bx_q; ry_q <= by_q; rinf_q <= 1'b0;
        end else if (x_same && !(pq_same && py != '0)) begin
          rx_q <= '0; ry_q <= '0; rinf_q <= 1'b1;
        end else if (!pq_same) begin
          t_q <= fsub(by_q, py, p_q);
          r0_q <= fsub(bx_q, px, p_q);
          r1_q <= p_q;
          c0_q <= W'(1);
          c1_q <= '0;
        end
      end
      S_D0: if (udone) t_q <= ures;
      S_D1: if (udone) t_q <= fadd(ures, a_q, p_q);
      S_D2: if (udone) begin
        r0_q <= ures; r1_q <= p_q; c0_q <= W'(1); c1_q <= '0;
      end
      S_INVQ: if (udone) begin
        q_q <= uquot[W-1:0];
        r0_q <= r1_q;
        r1_q <= udivrem[W-1:0];
      end
      S_INVM: if (udone) begin
        c0_q <= c1_q;
        c1_q <= fsub(c0_q, ures, p_q);
      end
      S_SL: if (udone) m_q <= ures;
      S_X0: if (udone) t_q <= ures;
      S_X1: rx_q <= fsub(fsub(t_q, bx_q, p_q), px, p_q);
      S_Y0: if (udone) t_q <= fadd(ures, py, p_q);
      S_Y1: begin
        ry_q <= fsub('0, t_q, p_q);
        rinf_q <= 1'b0;
      end
      S_WR: begin
        if (dst_acc_q) begin
          ax_q <= rx_q; ay_q <= ry_q; ainf_q <= rinf_q; dst_acc_q <= 1'b0;
        end else begin
          bx_q <= rx_q; by_q <= ry_q; binf_q <= rinf_q; k_q <= {1'b0, k_q[63:1]};
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ov_q;
  assign result_x_o = 64'(res_x_q);
  assign result_y_o = 64'(res_y_q);
  assign result_is_infinity_o = res_inf_q;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_x_o) &&
      $stable(result_y_o) && $stable(result_is_infinity_o))) else $error("result word changed");
  a_inf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && result_is_infinity_o) |-> (result_x_o == '0 && result_y_o == '0))
    else $error("inf with coords");
  a_unit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ustart |=> busy_q) else $error("unit failed to start");
  a_unit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ustart |-> !busy_q) else $error("unit started while busy");

endmodule
